/* sv/assert_macros.svh */
// Assertion macros for the RTL of the batch size tuner.
// Both expect a signal clk, and ABST_ASSERT also rst, where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ABST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ABST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/abst_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive batch size tuner package
// Field widths, event and flag types, register indexes and tuning constants.
// ----------------------------------------------------------------------------
package abst_pkg;

  localparam int SIZE_W      = 16;
  localparam int FLIGHT_W    = 8;
  localparam int HIT_W       = 5;
  localparam int CFG_INDEX_W = 1;

  localparam int CEILING_RESET   = 64;
  localparam int FIRST_RESET     = 8;
  localparam int FIRST_GROW      = 5;
  localparam int MAX_SHRINK      = 2;
  localparam int FLIGHT_MIN      = 2;
  localparam int HIT_STEP        = 2;
  localparam int HIT_MAX         = 31;
  localparam int HIT_DECAY_LIMIT = 8;
  localparam int HIT_RESET_LIMIT = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_CEILING,
    REG_FIRST_INITIAL
  } cfg_reg_t;

  typedef enum logic {
    MODE_BATCH_END,
    MODE_EMPTY_FLUSH
  } evt_mode_t;

  typedef struct packed {
    logic                mode;
    logic                has_batch;
    logic                by_flush;
    logic                executor_idle;
    logic [SIZE_W-1:0]   cmd_count;
    logic [FLIGHT_W-1:0] batches_in_flight;
  } evt_t;

  typedef struct packed {
    logic saw_empty_pipe;
    logic saw_idle_executor;
  } flags_t;

endpackage

/* sv/abst_if.sv */
// ----------------------------------------------------------------------------
// Adaptive batch size tuner channels
// Valid/ready interfaces for events, results and configuration writes.
// ----------------------------------------------------------------------------
interface abst_evt_if import abst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic                has_batch;
  logic                by_flush;
  logic                executor_idle;
  logic [SIZE_W-1:0]   cmd_count;
  logic [FLIGHT_W-1:0] batches_in_flight;

  modport source (
    output valid, mode, has_batch, by_flush, executor_idle, cmd_count, batches_in_flight,
    input  ready
  );
  modport sink (
    input  valid, mode, has_batch, by_flush, executor_idle, cmd_count, batches_in_flight,
    output ready
  );
endinterface

interface abst_res_if import abst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] batch_limit;
  logic [SIZE_W-1:0] first_batch_size;
  logic [SIZE_W-1:0] first_batch_floor;
  logic [HIT_W-1:0]  floor_hits;

  modport source (
    output valid, batch_limit, first_batch_size, first_batch_floor, floor_hits,
    input  ready
  );
  modport sink (
    input  valid, batch_limit, first_batch_size, first_batch_floor, floor_hits,
    output ready
  );
endinterface

interface abst_cfg_if import abst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [SIZE_W-1:0]      data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* sv/abst_update.sv */
// ----------------------------------------------------------------------------
// Adaptive batch size tuner update
// Next tuning state from the current state and one registered event.
// ----------------------------------------------------------------------------
module abst_update import abst_pkg::*; #(
  parameter int SIZE_BITS = 16
) (
  input  evt_t                 evt,
  input  logic [SIZE_BITS-1:0] ceiling,
  input  logic [SIZE_BITS-1:0] first_init,
  input  logic [SIZE_BITS-1:0] max_size,
  input  logic [SIZE_BITS-1:0] first_size,
  input  logic [SIZE_BITS-1:0] first_floor,
  input  logic [HIT_W-1:0]     hits,
  input  logic [SIZE_BITS-1:0] prev_size,
  input  flags_t               flags,
  output logic [SIZE_BITS-1:0] max_size_next,
  output logic [SIZE_BITS-1:0] first_size_next,
  output logic [SIZE_BITS-1:0] first_floor_next,
  output logic [HIT_W-1:0]     hits_next,
  output logic [SIZE_BITS-1:0] prev_size_next,
  output flags_t               flags_next
);

  function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                    input logic [SIZE_BITS-1:0] b);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_BITS] ? '1 : s[SIZE_BITS-1:0];
  endfunction

  // A flush grows the maximum by a depth over 2 unless the pipe ran empty.
  function automatic logic [SIZE_BITS-1:0] flush_grow(input logic [SIZE_BITS-1:0] mx,
                                                       input logic                 empty_seen,
                                                       input logic [SIZE_BITS-1:0] depth);
    return (depth > SIZE_BITS'(FLIGHT_MIN) && !empty_seen) ? sat_add(mx, depth) : mx;
  endfunction

  logic [SIZE_BITS-1:0] size;
  logic [SIZE_BITS-1:0] depth;
  logic [SIZE_BITS-1:0] mx;
  logic [SIZE_BITS-1:0] fs;
  logic [SIZE_BITS-1:0] fl;
  logic [HIT_W-1:0]     hc;
  logic [HIT_W:0]       hc_bump;
  logic [SIZE_BITS-1:0] pv;
  flags_t               fg;

  assign size  = SIZE_BITS'(evt.cmd_count);
  assign depth = SIZE_BITS'(evt.batches_in_flight);

  always_comb begin
    mx      = max_size;
    fs      = first_size;
    fl      = first_floor;
    hc      = hits;
    pv      = prev_size;
    fg      = flags;
    hc_bump = '0;
    if (evt.mode == MODE_EMPTY_FLUSH || (!evt.has_batch && evt.by_flush)) begin
      mx = flush_grow(mx, fg.saw_empty_pipe, depth);
      pv = '0;
      fg = '0;
    end else if (evt.has_batch) begin
      fg.saw_idle_executor = fg.saw_idle_executor | evt.executor_idle;
      if (pv == '0) begin
        pv = size;
      end else begin
        fg.saw_empty_pipe = fg.saw_empty_pipe | (depth == '0);
        if (depth == '0 && pv == fs) begin
          fl = sat_add(fs, SIZE_BITS'(1));
          hc = '0;
          fs = sat_add(fs, SIZE_BITS'(FIRST_GROW));
          mx = fs;
        end else if (depth == '0 &&
                     {1'b0, mx} >= ({1'b0, fs} + (SIZE_BITS+1)'(MAX_SHRINK))) begin
          mx = mx - SIZE_BITS'(MAX_SHRINK);
        end else if (depth != '0 && pv <= fs && fg.saw_idle_executor) begin
          fs = (fs != '0) ? fs - SIZE_BITS'(1) : '0;
        end

        if (evt.by_flush) begin
          if (!fg.saw_idle_executor && hc != '0) begin
            hc = hc - HIT_W'(1);
          end
          mx = flush_grow(mx, fg.saw_empty_pipe, depth);
          pv = '0;
          fg = '0;
        end else begin
          pv = size;
        end

        if (mx > ceiling) begin
          mx = ceiling;
        end

        if (fs < fl) begin
          hc_bump = {1'b0, hc} + (HIT_W+1)'(HIT_STEP);
          hc = (hc_bump > (HIT_W+1)'(HIT_MAX)) ? HIT_W'(HIT_MAX) : hc_bump[HIT_W-1:0];
          if (hc > HIT_W'(HIT_DECAY_LIMIT) && fl > SIZE_BITS'(1)) begin
            hc = '0;
            fl = fl - SIZE_BITS'(1);
          end else if (hc > HIT_W'(HIT_RESET_LIMIT) && fl == SIZE_BITS'(1)) begin
            hc = '0;
            fl = first_init;
          end else begin
            fs = fl;
          end
        end

        if (mx < fs) begin
          fs = mx;
        end
      end
    end
    max_size_next    = mx;
    first_size_next  = fs;
    first_floor_next = fl;
    hits_next        = hc;
    prev_size_next   = pv;
    flags_next       = fg;
  end

endmodule

/* sv/adaptive_batch_size_tuner_core.sv */
// ----------------------------------------------------------------------------
// Adaptive batch size tuner core
// Adapts maximum and first-batch sizes of a command queue from batch events.
// ----------------------------------------------------------------------------
// Usage:
// The evt channel takes one event per beat: a batch end (with or without a
// flush) or an empty flush, with the batch size, the batches in flight and
// the executor idle flag. Every event yields exactly one beat on the res
// channel with the maximum batch size, first-batch size, floor and floor hit
// count after that event. The cfg channel writes the ceiling (index 0) or the
// initial first-batch size (index 1); it is always ready and is meant to be
// used only while no event is in progress.
// An accepted event waits in the input register and moves to the result
// register once res can advance. The update is combinational between the
// two registers, so one event per cycle is sustained while res is ready.
// When the receiver stalls, the result register holds and the input register
// still takes one more event; after that evt.ready drops until res moves.
// Synchronous reset restores the ceiling to 64, the first-batch size and the
// floor to 8, clears the hit count, the last batch size and both flags, and
// empties both pipeline registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adaptive_batch_size_tuner_core import abst_pkg::*; #(
  parameter int SIZE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  abst_cfg_if.sink   cfg,
  abst_evt_if.sink   evt,
  abst_res_if.source res
);

  logic                 s1_valid;
  evt_t                 s1_evt;
  logic                 res_valid;
  logic                 advance;
  logic                 evt_accept;

  logic [SIZE_BITS-1:0] ceiling;
  logic [SIZE_BITS-1:0] first_init;
  logic [SIZE_BITS-1:0] max_size;
  logic [SIZE_BITS-1:0] first_size;
  logic [SIZE_BITS-1:0] first_floor;
  logic [HIT_W-1:0]     hits;
  logic [SIZE_BITS-1:0] prev_size;
  flags_t               flags;

  logic [SIZE_BITS-1:0] max_size_next;
  logic [SIZE_BITS-1:0] first_size_next;
  logic [SIZE_BITS-1:0] first_floor_next;
  logic [HIT_W-1:0]     hits_next;
  logic [SIZE_BITS-1:0] prev_size_next;
  flags_t               flags_next;
  logic [SIZE_BITS-1:0] cfg_value;

  assign advance    = !res_valid || res.ready;
  assign evt.ready  = !s1_valid || advance;
  assign evt_accept = evt.valid && evt.ready;
  assign cfg.ready  = 1'b1;
  assign res.valid  = res_valid;
  assign cfg_value  = SIZE_BITS'(cfg.data);

  abst_update #(
    .SIZE_BITS (SIZE_BITS)
  ) u_update (
    .evt              (s1_evt),
    .ceiling          (ceiling),
    .first_init       (first_init),
    .max_size         (max_size),
    .first_size       (first_size),
    .first_floor      (first_floor),
    .hits             (hits),
    .prev_size        (prev_size),
    .flags            (flags),
    .max_size_next    (max_size_next),
    .first_size_next  (first_size_next),
    .first_floor_next (first_floor_next),
    .hits_next        (hits_next),
    .prev_size_next   (prev_size_next),
    .flags_next       (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (evt_accept) begin
      s1_evt.mode              <= evt.mode;
      s1_evt.has_batch         <= evt.has_batch;
      s1_evt.by_flush          <= evt.by_flush;
      s1_evt.executor_idle     <= evt.executor_idle;
      s1_evt.cmd_count         <= evt.cmd_count;
      s1_evt.batches_in_flight <= evt.batches_in_flight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      res.batch_limit       <= SIZE_W'(max_size_next);
      res.first_batch_size  <= SIZE_W'(first_size_next);
      res.first_batch_floor <= SIZE_W'(first_floor_next);
      res.floor_hits        <= hits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling     <= SIZE_BITS'(CEILING_RESET);
      first_init  <= SIZE_BITS'(FIRST_RESET);
      max_size    <= SIZE_BITS'(CEILING_RESET);
      first_size  <= SIZE_BITS'(FIRST_RESET);
      first_floor <= SIZE_BITS'(FIRST_RESET);
      hits        <= '0;
      prev_size   <= '0;
      flags       <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAX_CEILING: begin
          ceiling  <= cfg_value;
          max_size <= cfg_value;
        end
        REG_FIRST_INITIAL: begin
          first_init  <= cfg_value;
          first_size  <= cfg_value;
          first_floor <= cfg_value;
        end
        default: begin
        end
      endcase
    end else if (advance && s1_valid) begin
      max_size    <= max_size_next;
      first_size  <= first_size_next;
      first_floor <= first_floor_next;
      hits        <= hits_next;
      prev_size   <= prev_size_next;
      flags       <= flags_next;
    end
  end

  `ABST_ASSERT(a_accept_lands, (evt_accept |=> s1_valid), "accepted event beat was dropped")
  `ABST_ASSERT(a_stage_moves, ((s1_valid && advance) |=> res_valid), "event did not reach result")
  `ABST_ASSERT(a_floor_kept, ((first_floor != '0) || (first_init == '0)), "floor fell to zero")

endmodule

/* verif/tb_adaptive_batch_size_tuner_core.sv */
// ----------------------------------------------------------------------------
// Adaptive batch size tuner core testbench
// Sends batch end, flush and empty flush events through the event channel. The
// sender and the receiver idle at random. Each result beat is compared with
// the sizes that a local predictor of the tuner works out for every accepted
// event. The configuration registers are rewritten between phases, with
// their extreme values among them.
// ----------------------------------------------------------------------------
module tb_adaptive_batch_size_tuner_core;
  import abst_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 7;
  localparam int PHASE_EVENTS  = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [SIZE_W-1:0] SIZE_TOP = '1;

  typedef struct packed {
    logic [SIZE_W-1:0] max_size;
    logic [SIZE_W-1:0] first_size;
    logic [SIZE_W-1:0] floor;
    logic [HIT_W-1:0]  hits;
  } sizes_t;

  logic clk = 1'b0;
  logic rst;

  abst_cfg_if cfg_ch ();
  abst_evt_if evt_ch ();
  abst_res_if res_ch ();

  adaptive_batch_size_tuner_core #(.SIZE_BITS(SIZE_W)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .evt (evt_ch),
    .res (res_ch)
  );

  logic [SIZE_W-1:0] ceiling_cfg;
  logic [SIZE_W-1:0] first_init_cfg;
  sizes_t            tuned;
  logic [SIZE_W-1:0] last_size;
  flags_t            seen;
  sizes_t            expected_sizes[$];

  int errors       = 0;
  int events_sent  = 0;
  int results_seen = 0;
  int cfg_phases   = 0;
  int cycles       = 0;
  int hold_off     = 0;
  bit send_calm    = 1'b0;
  bit recv_calm    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d results outstanding",
               $time, cycles, expected_sizes.size());
      $display("tb_adaptive_batch_size_tuner_core: FAIL");
      $finish;
    end
  end

  function automatic logic [SIZE_W-1:0] size_plus(logic [SIZE_W-1:0] a, int unsigned b);
    int unsigned sum;
    sum = a + b;
    return (sum > SIZE_TOP) ? SIZE_TOP : sum[SIZE_W-1:0];
  endfunction

  function automatic void clear_after_flush(logic [FLIGHT_W-1:0] flight);
    if (flight > FLIGHT_MIN && !seen.saw_empty_pipe)
      tuned.max_size = size_plus(tuned.max_size, flight);
    last_size = '0;
    seen = '0;
  endfunction

  function automatic void tune_on_event(evt_t ev);
    logic [FLIGHT_W-1:0] flight;
    flight = ev.batches_in_flight;
    if (ev.mode == MODE_EMPTY_FLUSH || !ev.has_batch) begin
      if (ev.mode == MODE_EMPTY_FLUSH || ev.by_flush)
        clear_after_flush(flight);
      return;
    end
    seen.saw_idle_executor = seen.saw_idle_executor | ev.executor_idle;
    // The first batch after a flush only records its size.
    if (last_size == '0) begin
      last_size = ev.cmd_count;
      return;
    end
    seen.saw_empty_pipe = seen.saw_empty_pipe | (flight == '0);

    if (flight == '0 && last_size == tuned.first_size) begin
      tuned.floor      = size_plus(tuned.first_size, 1);
      tuned.hits       = '0;
      tuned.first_size = size_plus(tuned.first_size, FIRST_GROW);
      tuned.max_size   = tuned.first_size;
    end else if (flight == '0 && tuned.max_size >= tuned.first_size + MAX_SHRINK) begin
      tuned.max_size = SIZE_W'(tuned.max_size - MAX_SHRINK);
    end else if (flight != '0 && last_size <= tuned.first_size && seen.saw_idle_executor) begin
      tuned.first_size = (tuned.first_size == '0) ? '0 : tuned.first_size - 1'b1;
    end

    if (ev.by_flush) begin
      if (!seen.saw_idle_executor && tuned.hits != '0)
        tuned.hits = tuned.hits - 1'b1;
      clear_after_flush(flight);
    end else begin
      last_size = ev.cmd_count;
    end

    if (tuned.max_size > ceiling_cfg)
      tuned.max_size = ceiling_cfg;

    if (tuned.first_size < tuned.floor) begin
      tuned.hits = HIT_W'((tuned.hits + HIT_STEP > HIT_MAX) ? HIT_MAX : tuned.hits + HIT_STEP);
      if (tuned.hits > HIT_DECAY_LIMIT && tuned.floor > 1) begin
        tuned.hits  = '0;
        tuned.floor = tuned.floor - 1'b1;
      end else if (tuned.hits > HIT_RESET_LIMIT && tuned.floor == 1) begin
        tuned.hits  = '0;
        tuned.floor = first_init_cfg;
      end else begin
        tuned.first_size = tuned.floor;
      end
    end

    if (tuned.max_size < tuned.first_size)
      tuned.first_size = tuned.max_size;
  endfunction

  function automatic int pick_wait(bit calm);
    if (calm || $urandom_range(0, 1))
      return 0;
    return $urandom_range(1, 16);
  endfunction

  function automatic evt_t build_evt(evt_mode_t mode, int has_batch, int by_flush,
                                     int idle, logic [SIZE_W-1:0] size,
                                     logic [FLIGHT_W-1:0] flight);
    evt_t ev;
    ev.mode              = mode;
    ev.has_batch         = (has_batch != 0);
    ev.by_flush          = (by_flush != 0);
    ev.executor_idle     = (idle != 0);
    ev.cmd_count         = size;
    ev.batches_in_flight = flight;
    return ev;
  endfunction

  // Mostly batch ends, and half the sizes sit on or next to the first-batch size, so
  // that the grow, shrink and floor rules are reached; the rest is noise.
  function automatic evt_t random_event();
    evt_t ev;
    int   pick;
    pick = $urandom_range(0, 99);
    ev.mode          = (pick < 8) ? MODE_EMPTY_FLUSH : MODE_BATCH_END;
    ev.has_batch     = 1'((pick < 8) ? $urandom_range(0, 1) : (pick >= 16));
    ev.by_flush      = ($urandom_range(0, 4) == 0);
    ev.executor_idle = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2:    ev.batches_in_flight = '0;
      3, 4, 5, 6: ev.batches_in_flight = FLIGHT_W'($urandom_range(1, 4));
      default:    ev.batches_in_flight = FLIGHT_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:          ev.cmd_count = '0;
      1, 2, 3:    ev.cmd_count = tuned.first_size;
      4:          ev.cmd_count = size_plus(tuned.first_size, 1);
      5:          ev.cmd_count = (tuned.first_size == '0) ? '0 : tuned.first_size - 1'b1;
      6:          ev.cmd_count = SIZE_W'($urandom_range(0, 65535));
      default:    ev.cmd_count = SIZE_W'($urandom_range(1, 64));
    endcase
    return ev;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_event(evt_t ev);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid             <= 1'b1;
    evt_ch.mode              <= ev.mode;
    evt_ch.has_batch         <= ev.has_batch;
    evt_ch.by_flush          <= ev.by_flush;
    evt_ch.executor_idle     <= ev.executor_idle;
    evt_ch.cmd_count         <= ev.cmd_count;
    evt_ch.batches_in_flight <= ev.batches_in_flight;
    do @(posedge clk); while (!evt_ch.ready);
    tune_on_event(ev);
    expected_sizes.push_back(tuned);
    events_sent++;
  endtask

  task automatic drain_results();
    evt_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_sizes.size() != 0);
  endtask

  task automatic set_config(logic [SIZE_W-1:0] ceiling, logic [SIZE_W-1:0] first_init);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_MAX_CEILING;
    cfg_ch.data  <= ceiling;
    do @(posedge clk); while (!cfg_ch.ready);
    ceiling_cfg    = ceiling;
    tuned.max_size = ceiling;
    cfg_ch.index <= REG_FIRST_INITIAL;
    cfg_ch.data  <= first_init;
    do @(posedge clk); while (!cfg_ch.ready);
    first_init_cfg   = first_init;
    tuned.first_size = first_init;
    tuned.floor      = first_init;
    cfg_ch.valid <= 1'b0;
    cfg_phases++;
  endtask

  task automatic test_reset_values();
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd8, 8'd1));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd8, 8'd0));
  endtask

  task automatic test_event_kinds();
    send_event(build_evt(MODE_EMPTY_FLUSH, 0, 0, 0, 16'd0, 8'd5));
    send_event(build_evt(MODE_EMPTY_FLUSH, 1, 1, 1, 16'hFFFF, 8'd0));
    send_event(build_evt(MODE_EMPTY_FLUSH, 0, 1, 0, 16'd1234, 8'hFF));
    send_event(build_evt(MODE_BATCH_END, 0, 0, 1, 16'd77, 8'd9));
    send_event(build_evt(MODE_BATCH_END, 0, 1, 0, 16'd77, 8'd3));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd0, 8'd2));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 1, 16'd5, 8'd2));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd5, 8'd1));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd40, 8'd0));
    send_event(build_evt(MODE_BATCH_END, 1, 1, 0, 16'd3, 8'd6));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd20, 8'd4));
    send_event(build_evt(MODE_BATCH_END, 1, 1, 1, 16'd20, 8'd7));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'hFFFF, 8'hFF));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'hAAAA, 8'h55));
    send_event(build_evt(MODE_BATCH_END, 1, 1, 0, 16'h5555, 8'hAA));
  endtask

  task automatic test_saturation();
    set_config(16'hFFFF, 16'hFFFF);
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'hFFFF, 8'd1));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'hFFFF, 8'd0));
    send_event(build_evt(MODE_BATCH_END, 1, 1, 0, 16'd1, 8'hFF));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd9, 8'd3));
    send_event(build_evt(MODE_BATCH_END, 1, 1, 0, 16'd9, 8'hFF));
    send_event(build_evt(MODE_EMPTY_FLUSH, 0, 0, 0, 16'd0, 8'hFF));
  endtask

  task automatic test_zero_registers();
    set_config(16'd0, 16'd0);
    send_event(build_evt(MODE_BATCH_END, 1, 0, 1, 16'd5, 8'd0));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 1, 16'd5, 8'd0));
    send_event(build_evt(MODE_EMPTY_FLUSH, 0, 0, 0, 16'd0, 8'd200));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd3, 8'd1));
    send_event(build_evt(MODE_BATCH_END, 1, 0, 0, 16'd3, 8'd0));
    set_config(16'd0, 16'd8);
    repeat (4) send_event(build_evt(MODE_BATCH_END, 1, 0, 1, 16'd2, 8'd1));
  endtask

  // The floor walks down to one and then jumps back to the initial size.
  task automatic test_floor_corner();
    set_config(16'd64, 16'd2);
    repeat (20) send_event(build_evt(MODE_BATCH_END, 1, 0, 1, 16'd1, 8'd1));
  endtask

  task automatic test_backpressure();
    send_calm = 1'b1;
    hold_off  = 150;
    repeat (40) send_event(random_event());
    send_calm = 1'b0;
    drain_results();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_config(16'd1, 16'd1);
        1:       set_config(16'hFFFF, 16'd1);
        2:       set_config(16'd64, 16'd8);
        3:       set_config(16'hFFFF, 16'hFFFF);
        4:       set_config(SIZE_W'($urandom_range(16, 300)), SIZE_W'($urandom_range(1, 40)));
        5:       set_config(16'd1, 16'hFFFF);
        default: set_config(SIZE_W'($urandom_range(1, 65535)),
                            SIZE_W'($urandom_range(1, 65535)));
      endcase
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        if (i % 50 == 0) begin
          send_calm = ($urandom_range(0, 3) == 0);
          recv_calm = ($urandom_range(0, 3) == 0);
        end
        send_event(random_event());
      end
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;
  endtask

  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end else begin
        stall = pick_wait(recv_calm);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (expected_sizes.size() == 0) begin
        errors++;
        $display("%0t: result beat with no event waiting: max %0d first %0d floor %0d hits %0d",
                 $time, res_ch.batch_limit, res_ch.first_batch_size,
                 res_ch.first_batch_floor, res_ch.floor_hits);
      end else begin
        sizes_t want;
        want = expected_sizes.pop_front();
        results_seen++;
        check_field("batch_limit", want.max_size, res_ch.batch_limit);
        check_field("first_batch_size", want.first_size, res_ch.first_batch_size);
        check_field("first_batch_floor", want.floor, res_ch.first_batch_floor);
        check_field("floor_hits", want.hits, res_ch.floor_hits);
      end
    end
  end

  initial begin
    rst                      <= 1'b1;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= REG_MAX_CEILING;
    cfg_ch.data              <= '0;
    evt_ch.valid             <= 1'b0;
    evt_ch.mode              <= MODE_BATCH_END;
    evt_ch.has_batch         <= 1'b0;
    evt_ch.by_flush          <= 1'b0;
    evt_ch.executor_idle     <= 1'b0;
    evt_ch.cmd_count         <= '0;
    evt_ch.batches_in_flight <= '0;
    ceiling_cfg      = SIZE_W'(CEILING_RESET);
    first_init_cfg   = SIZE_W'(FIRST_RESET);
    tuned.max_size   = SIZE_W'(CEILING_RESET);
    tuned.first_size = SIZE_W'(FIRST_RESET);
    tuned.floor      = SIZE_W'(FIRST_RESET);
    tuned.hits       = '0;
    last_size        = '0;
    seen             = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_event_kinds();
    test_saturation();
    test_zero_registers();
    test_floor_corner();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d events over %0d register settings,",
             results_seen, events_sent, cfg_phases);
    $display("covering flushes, floor walks, saturation, zero registers and long stalls.");
    if (errors == 0) begin
      $display("tb_adaptive_batch_size_tuner_core: PASS");
    end else begin
      $display("%0d mismatches found", errors);
      $display("tb_adaptive_batch_size_tuner_core: FAIL");
    end
    $finish;
  end

endmodule
